// ----- rtl/asdt_pkg.sv -----
// Shared types, constants and the seven-segment decode for the audio stream deframer.
// No dependencies.
package asdt_pkg;

	localparam int unsigned STRING_CAPACITY = 64;

	localparam logic [31:0] MAGIC_WORD  = 32'hDEADDA7A;
	localparam logic [12:0] MAX_SECONDS = 13'd5999;

	localparam logic [2:0] KIND_RATE     = 3'd0;
	localparam logic [2:0] KIND_CHANNELS = 3'd1;
	localparam logic [2:0] KIND_BITS     = 3'd2;
	localparam logic [2:0] KIND_LENGTH   = 3'd3;
	localparam logic [2:0] KIND_CHAR     = 3'd4;
	localparam logic [2:0] KIND_SAMPLE   = 3'd5;

	localparam logic [1:0] LAST_STRING = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [1:0]  string_select;
		logic [5:0]  char_position;
		logic        time_tick;
		logic [12:0] elapsed_seconds;
		logic [31:0] segment_pattern;
	} res_t;

	// active-low segment code of one decimal digit
	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h40;
			4'd1: s = 8'h79;
			4'd2: s = 8'h24;
			4'd3: s = 8'h30;
			4'd4: s = 8'h19;
			4'd5: s = 8'h12;
			4'd6: s = 8'h02;
			4'd7: s = 8'h78;
			4'd8: s = 8'h00;
			4'd9: s = 8'h10;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/audio_stream_deframer_timer_top.sv -----
// Audio stream deframer with mm:ss playback timer, top level.
// Depends on asdt_pkg.
//
// Takes one 32-bit stream word per clock cycle while the skid register is empty, and gives
// at most one result beat per word; words seen while hunting for the magic word, and the
// magic word itself, give no beat. Each word is decoded combinationally from the current
// parse state and the result lands in a two-entry output buffer (output register plus skid
// register), so input keeps flowing at one word per cycle while one result waits to be
// taken. The time is kept as four decimal digit counters next to the binary seconds count,
// so the segment pattern is a table lookup per digit.
module audio_stream_deframer_timer_top #(
	parameter int unsigned STRING_CAPACITY = asdt_pkg::STRING_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] fifo_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] value,
	output logic [1:0]  string_select,
	output logic [5:0]  char_position,
	output logic        time_tick,
	output logic [12:0] elapsed_seconds,
	output logic [31:0] segment_pattern
);

	localparam int unsigned CNT_W = ($clog2(STRING_CAPACITY) > 6) ? $clog2(STRING_CAPACITY) : 6;

	typedef enum logic [2:0] {
		PH_HUNT, PH_RATE, PH_CHANNELS, PH_BITS, PH_LENGTH, PH_CHARS, PH_AUDIO
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [1:0]         str_q, str_n;
	logic [CNT_W-1:0]   rem_q, rem_n;
	logic [CNT_W-1:0]   pos_q, pos_n;
	logic [31:0]        rate_q, rate_n;
	logic [31:0]        chans_q, chans_n;
	logic [31:0]        bits_q, bits_n;
	logic [31:0]        smp_q, smp_n;
	logic [12:0]        secs_q, secs_n;
	logic [3:0]         su_q, st_q, mu_q, mt_q;
	logic [3:0]         su_n, st_n, mu_n, mt_n;

	asdt_pkg::res_t     res, out_q, skid_q;
	logic               res_v;
	logic               out_v_q, skid_v_q;
	logic               in_fire, out_fire, new_res;

	logic [31:0]        smp_inc;
	logic [CNT_W-1:0]   len;
	logic [CNT_W-1:0]   rem_dec;

	always_comb begin
		phase_n = phase_q;
		str_n   = str_q;
		rem_n   = rem_q;
		pos_n   = pos_q;
		rate_n  = rate_q;
		chans_n = chans_q;
		bits_n  = bits_q;
		smp_n   = smp_q;
		secs_n  = secs_q;
		su_n    = su_q;
		st_n    = st_q;
		mu_n    = mu_q;
		mt_n    = mt_q;
		res_v   = 1'b1;
		res     = '0;
		smp_inc = smp_q + 32'd1;
		rem_dec = rem_q - CNT_W'(1);
		if (fifo_word >= 32'(STRING_CAPACITY))
			len = CNT_W'(STRING_CAPACITY - 1);
		else
			len = fifo_word[CNT_W-1:0];

		unique case (phase_q)
			PH_HUNT: begin
				res_v = 1'b0;
				if (fifo_word == asdt_pkg::MAGIC_WORD)
					phase_n = PH_RATE;
			end
			PH_RATE: begin
				rate_n    = fifo_word;
				res.kind  = asdt_pkg::KIND_RATE;
				res.value = fifo_word;
				phase_n   = PH_CHANNELS;
			end
			PH_CHANNELS: begin
				chans_n   = fifo_word;
				res.kind  = asdt_pkg::KIND_CHANNELS;
				res.value = fifo_word;
				phase_n   = PH_BITS;
			end
			PH_BITS: begin
				bits_n    = fifo_word;
				res.kind  = asdt_pkg::KIND_BITS;
				res.value = fifo_word;
				str_n     = 2'd0;
				phase_n   = PH_LENGTH;
			end
			PH_LENGTH: begin
				res.kind          = asdt_pkg::KIND_LENGTH;
				res.value         = 32'(len);
				res.string_select = str_q;
				rem_n             = len;
				pos_n             = '0;
				if (len == '0) begin
					if (str_q >= asdt_pkg::LAST_STRING) begin
						str_n   = 2'd0;
						phase_n = PH_AUDIO;
					end else begin
						str_n   = str_q + 2'd1;
						phase_n = PH_LENGTH;
					end
				end else begin
					phase_n = PH_CHARS;
				end
			end
			PH_CHARS: begin
				res.kind          = asdt_pkg::KIND_CHAR;
				res.value         = {24'd0, fifo_word[7:0]};
				res.string_select = str_q;
				res.char_position = pos_q[5:0];
				pos_n             = pos_q + CNT_W'(1);
				rem_n             = rem_dec;
				if (rem_dec == '0) begin
					if (str_q >= asdt_pkg::LAST_STRING) begin
						str_n   = 2'd0;
						phase_n = PH_AUDIO;
					end else begin
						str_n   = str_q + 2'd1;
						phase_n = PH_LENGTH;
					end
				end
			end
			default: begin
				phase_n   = PH_AUDIO;
				res.kind  = asdt_pkg::KIND_SAMPLE;
				res.value = {fifo_word[15:0], 16'd0};
				smp_n     = smp_inc;
				if (smp_inc >= rate_q) begin
					smp_n = 32'd0;
					if (secs_q < asdt_pkg::MAX_SECONDS) begin
						secs_n        = secs_q + 13'd1;
						res.time_tick = 1'b1;
						if (su_q == 4'd9) begin
							su_n = 4'd0;
							if (st_q == 4'd5) begin
								st_n = 4'd0;
								if (mu_q == 4'd9) begin
									mu_n = 4'd0;
									mt_n = mt_q + 4'd1;
								end else begin
									mu_n = mu_q + 4'd1;
								end
							end else begin
								st_n = st_q + 4'd1;
							end
						end else begin
							su_n = su_q + 4'd1;
						end
					end
				end
			end
		endcase

		res.elapsed_seconds = secs_n;
		res.segment_pattern = {asdt_pkg::seg_of(mt_n), asdt_pkg::seg_of(mu_n),
		                       asdt_pkg::seg_of(st_n), asdt_pkg::seg_of(su_n)};
	end

	assign in_ready = !skid_v_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_v_q && out_ready;
	assign new_res  = in_fire && res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			str_q   <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			rate_q  <= '0;
			chans_q <= '0;
			bits_q  <= '0;
			smp_q   <= '0;
			secs_q  <= '0;
			su_q    <= '0;
			st_q    <= '0;
			mu_q    <= '0;
			mt_q    <= '0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			str_q   <= str_n;
			rem_q   <= rem_n;
			pos_q   <= pos_n;
			rate_q  <= rate_n;
			chans_q <= chans_n;
			bits_q  <= bits_n;
			smp_q   <= smp_n;
			secs_q  <= secs_n;
			su_q    <= su_n;
			st_q    <= st_n;
			mu_q    <= mu_n;
			mt_q    <= mt_n;
		end
	end

	// two-entry result buffer: output register, then skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= new_res;
			end else begin
				out_v_q <= new_res;
			end
		end else if (!out_v_q) begin
			out_v_q <= new_res;
		end else if (new_res) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (new_res)
					skid_q <= res;
			end else if (new_res) begin
				out_q <= res;
			end
		end else if (!out_v_q) begin
			if (new_res)
				out_q <= res;
		end else if (new_res) begin
			skid_q <= res;
		end
	end

	assign out_valid       = out_v_q;
	assign kind            = out_q.kind;
	assign value           = out_q.value;
	assign string_select   = out_q.string_select;
	assign char_position   = out_q.char_position;
	assign time_tick       = out_q.time_tick;
	assign elapsed_seconds = out_q.elapsed_seconds;
	assign segment_pattern = out_q.segment_pattern;

endmodule

// ----- rtl/asdt_checker.sv -----
// Port-level checks for audio_stream_deframer_timer_top, attached by bind.
// Depends on asdt_pkg.
module asdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] fifo_word,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [31:0] value,
	input logic [1:0]  string_select,
	input logic [5:0]  char_position,
	input logic        time_tick,
	input logic [12:0] elapsed_seconds,
	input logic [31:0] segment_pattern
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(kind))
		else $error("result beat changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= asdt_pkg::KIND_SAMPLE)
		else $error("result kind out of range");

	a_tick_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != asdt_pkg::KIND_SAMPLE |-> !time_tick)
		else $error("tick on a non-sample beat");

	a_secs_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> elapsed_seconds <= asdt_pkg::MAX_SECONDS)
		else $error("elapsed seconds past saturation");

	a_str_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == asdt_pkg::KIND_LENGTH || kind == asdt_pkg::KIND_CHAR)
		|-> string_select <= asdt_pkg::LAST_STRING)
		else $error("string select out of range");

endmodule

bind audio_stream_deframer_timer_top asdt_checker u_asdt_checker (.*);
